// ===== design/chtt_pkg.sv =====
// Shared types, command and status codes and small helper functions for the
// chained hash tag table. No dependencies.
package chtt_pkg;

  localparam int MAX_BUCKETS = 16;
  localparam int BKT_W       = 4;
  localparam int HASH_SHIFT  = 28;

  localparam logic [31:0] HASH_MUL      = 32'd2654435769;
  localparam logic [4:0]  BUCKETS_RESET = 5'd16;

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_REM_TAG  = 3'd1;
  localparam logic [2:0] CMD_REM_SLOT = 3'd2;
  localparam logic [2:0] CMD_RESTART  = 3'd3;
  localparam logic [2:0] CMD_NEXT     = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] tag;
    logic [5:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] tag_out;
    logic [6:0]  item_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_HASH_A,
    S_HASH_B,
    S_HEAD,
    S_SEARCH,
    S_CMP,
    S_WALK,
    S_VISIT,
    S_DONE
  } state_t;

  // Bucket count register mapped onto the usable range.
  function automatic logic [4:0] depth_of(input logic [4:0] bc);
    logic [4:0] d;
    if (bc == 5'd0) begin
      d = 5'd1;
    end else if (bc > 5'(MAX_BUCKETS)) begin
      d = 5'(MAX_BUCKETS);
    end else begin
      d = bc;
    end
    return d;
  endfunction

  // Restoring remainder of a four-bit value by a divisor of 1 to 16.
  function automatic logic [BKT_W-1:0] bucket_mod(input logic [BKT_W-1:0] v,
                                                  input logic [4:0] d);
    logic [4:0] r;
    r = '0;
    for (int i = BKT_W - 1; i >= 0; i--) begin
      r = {r[3:0], v[i]};
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[BKT_W-1:0];
  endfunction

endpackage

// ===== design/chtt_entry_mem.sv =====
// Entry store of the chained hash tag table: tag and chain link per slot.
// Simple dual-port synchronous RAM with registered read data; no dependencies.
module chtt_entry_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 39
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/chtt_hash.sv =====
// Two-stage bucket hash: multiplicative hash of the tag, then the remainder
// by the bucket count in use. Depends on chtt_pkg.
module chtt_hash (
  input  logic                       clk,
  input  logic [31:0]                tag,
  input  logic [4:0]                 depth,
  output logic [chtt_pkg::BKT_W-1:0] bucket
);

  logic [31:0]                prod;
  logic [chtt_pkg::BKT_W-1:0] prod_hi;

  // Only the low word of the product is kept.
  assign prod = tag * chtt_pkg::HASH_MUL;

  always_ff @(posedge clk) begin
    prod_hi <= prod[chtt_pkg::HASH_SHIFT +: chtt_pkg::BKT_W];
    bucket  <= chtt_pkg::bucket_mod(prod_hi, depth);
  end

endmodule

// ===== design/chained_hash_tag_table.sv =====
// Chained hash tag table: one request at a time. Add hashes the tag and links the lowest free
// slot in at the bucket head; remove by tag hashes, then walks the chain to a hit or its end;
// remove by slot first reads the slot's tag; next passes over empty buckets to the next entry.
// A chain step is a read on the entry RAM port, then a compare. A request is taken the cycle
// after the previous result is registered. Synchronous reset clears bucket heads, valid bits,
// count and walk state, not the entry RAM.
module chained_hash_tag_table #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  chtt_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output chtt_pkg::rsp_t   rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = SW + 1;
  localparam int XW = (LW > 7) ? LW : 7;
  localparam int DW = 32 + LW;
  localparam logic [LW-1:0] NIL       = LW'(SLOTS);
  localparam logic [LW-1:0] GUARD_END = LW'(SLOTS);

  chtt_pkg::state_t state, state_next;

  logic [4:0]     bucket_count;
  logic [LW-1:0]  heads [chtt_pkg::MAX_BUCKETS];
  logic [SLOTS-1:0] valid;
  logic [LW-1:0]  cnt;
  logic [4:0]     walk_bucket;
  logic [LW-1:0]  walk_cursor;

  logic [2:0]     cmd_q;
  logic [31:0]    tag_q;
  logic [5:0]     slot_q;
  logic [LW-1:0]  cur;
  logic [LW-1:0]  prev;
  logic [31:0]    prev_tag;
  logic [LW-1:0]  guard;
  logic [1:0]     res_status;
  logic [5:0]     res_slot;
  logic [31:0]    res_tag;

  logic [4:0]                 depth;
  logic [chtt_pkg::BKT_W-1:0] bucket;
  logic [LW-1:0]              head_of_bucket;
  logic [XW-1:0]              slot_x;
  logic                       slot_in_pool;
  logic [SW-1:0]              slot_idx;
  logic                       slot_ok;
  logic [SW-1:0]              free_idx;
  logic                       any_free;
  logic [DW-1:0]              rdata;
  logic [31:0]                rd_tag;
  logic [LW-1:0]              rd_link;
  logic                       hit;
  logic                       search_end;
  logic                       wb_in_range;
  logic [LW-1:0]              walk_pick;
  logic                       rsp_free;
  logic [XW-1:0]              free_x;
  logic [XW-1:0]              cur_x;
  logic [XW-1:0]              wcur_x;
  logic [XW-1:0]              cnt_x;

  logic                       mem_we;
  logic [SW-1:0]              mem_waddr;
  logic [DW-1:0]              mem_wdata;
  logic [SW-1:0]              mem_raddr;

  chtt_entry_mem #(
    .DEPTH (SLOTS),
    .AW    (SW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  chtt_hash u_hash (
    .clk    (clk),
    .tag    (tag_q),
    .depth  (depth),
    .bucket (bucket)
  );

  assign depth          = chtt_pkg::depth_of(bucket_count);
  assign head_of_bucket = heads[bucket];
  assign slot_x         = XW'(slot_q);
  assign slot_in_pool   = slot_x < XW'(SLOTS);
  assign slot_idx       = slot_x[SW-1:0];
  assign slot_ok        = slot_in_pool && valid[slot_idx];
  assign rd_tag         = rdata[DW-1:LW];
  assign rd_link        = rdata[LW-1:0];
  assign hit            = rd_tag == tag_q;
  assign search_end     = (cur == NIL) || (guard == GUARD_END);
  assign wb_in_range    = walk_bucket < depth;
  assign walk_pick      = (walk_cursor == NIL) ? heads[walk_bucket[chtt_pkg::BKT_W-1:0]]
                                               : walk_cursor;
  assign rsp_free       = !rsp_valid || rsp_ready;
  assign free_x         = XW'(free_idx);
  assign cur_x          = XW'(cur);
  assign wcur_x         = XW'(walk_cursor);
  assign cnt_x          = XW'(cnt);
  assign cfg_ready      = 1'b1;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      chtt_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req.cmd)
            chtt_pkg::CMD_ADD:      state_next = chtt_pkg::S_HASH_A;
            chtt_pkg::CMD_REM_TAG:  state_next = chtt_pkg::S_HASH_A;
            chtt_pkg::CMD_REM_SLOT: state_next = chtt_pkg::S_SLOT_RD;
            chtt_pkg::CMD_NEXT:     state_next = chtt_pkg::S_WALK;
            default:                state_next = chtt_pkg::S_DONE;
          endcase
        end
      end
      chtt_pkg::S_SLOT_RD: begin
        state_next = slot_ok ? chtt_pkg::S_SLOT_CHK : chtt_pkg::S_DONE;
      end
      chtt_pkg::S_SLOT_CHK: state_next = chtt_pkg::S_HASH_A;
      chtt_pkg::S_HASH_A:   state_next = chtt_pkg::S_HASH_B;
      chtt_pkg::S_HASH_B:   state_next = chtt_pkg::S_HEAD;
      chtt_pkg::S_HEAD: begin
        state_next = (cmd_q == chtt_pkg::CMD_ADD) ? chtt_pkg::S_DONE : chtt_pkg::S_SEARCH;
      end
      chtt_pkg::S_SEARCH: begin
        state_next = search_end ? chtt_pkg::S_DONE : chtt_pkg::S_CMP;
      end
      chtt_pkg::S_CMP: begin
        state_next = hit ? chtt_pkg::S_DONE : chtt_pkg::S_SEARCH;
      end
      chtt_pkg::S_WALK: begin
        if (!wb_in_range) begin
          state_next = chtt_pkg::S_DONE;
        end else if (walk_pick != NIL) begin
          state_next = chtt_pkg::S_VISIT;
        end
      end
      chtt_pkg::S_VISIT: state_next = chtt_pkg::S_DONE;
      chtt_pkg::S_DONE: begin
        if (rsp_free) begin
          state_next = chtt_pkg::S_IDLE;
        end
      end
      default: state_next = chtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state)
      chtt_pkg::S_IDLE:    req_ready = 1'b1;
      chtt_pkg::S_SLOT_RD: mem_raddr = slot_idx;
      chtt_pkg::S_SEARCH:  mem_raddr = cur[SW-1:0];
      chtt_pkg::S_WALK:    mem_raddr = walk_pick[SW-1:0];
      chtt_pkg::S_HEAD: begin
        if (cmd_q == chtt_pkg::CMD_ADD && any_free) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = {tag_q, head_of_bucket};
        end
      end
      chtt_pkg::S_CMP: begin
        // Unlinking an entry behind the chain head rewrites the predecessor's link.
        if (hit && prev != NIL) begin
          mem_we    = 1'b1;
          mem_waddr = prev[SW-1:0];
          mem_wdata = {prev_tag, rd_link};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chtt_pkg::S_IDLE;
      bucket_count <= chtt_pkg::BUCKETS_RESET;
      for (int i = 0; i < chtt_pkg::MAX_BUCKETS; i++) begin
        heads[i] <= NIL;
      end
      valid        <= '0;
      cnt          <= '0;
      walk_bucket  <= '0;
      walk_cursor  <= NIL;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (state == chtt_pkg::S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        chtt_pkg::S_IDLE: begin
          if (req_valid && req.cmd == chtt_pkg::CMD_RESTART) begin
            walk_bucket <= '0;
            walk_cursor <= NIL;
          end
        end
        chtt_pkg::S_HEAD: begin
          if (cmd_q == chtt_pkg::CMD_ADD && any_free) begin
            heads[bucket]   <= LW'(free_idx);
            valid[free_idx] <= 1'b1;
            cnt             <= cnt + LW'(1);
          end
        end
        chtt_pkg::S_CMP: begin
          if (hit) begin
            if (prev == NIL) begin
              heads[bucket] <= rd_link;
            end
            valid[cur[SW-1:0]] <= 1'b0;
            if (cnt != '0) begin
              cnt <= cnt - LW'(1);
            end
            // A walk parked on the removed entry moves on to its successor.
            if (walk_cursor == cur) begin
              walk_cursor <= rd_link;
              if (rd_link == NIL && walk_bucket != 5'd31) begin
                walk_bucket <= walk_bucket + 5'd1;
              end
            end
          end
        end
        chtt_pkg::S_WALK: begin
          if (wb_in_range) begin
            walk_cursor <= walk_pick;
            if (walk_pick == NIL) begin
              walk_bucket <= walk_bucket + 5'd1;
            end
          end
        end
        chtt_pkg::S_VISIT: begin
          walk_cursor <= rd_link;
          if (rd_link == NIL) begin
            walk_bucket <= walk_bucket + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      chtt_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd_q      <= req.cmd;
          tag_q      <= req.tag;
          slot_q     <= req.slot_in;
          res_slot   <= '0;
          res_tag    <= '0;
          res_status <= (req.cmd == chtt_pkg::CMD_RESTART) ? chtt_pkg::ST_OK
                                                            : chtt_pkg::ST_NOT_FOUND;
        end
      end
      chtt_pkg::S_SLOT_CHK: tag_q <= rd_tag;
      chtt_pkg::S_HEAD: begin
        res_tag <= tag_q;
        if (cmd_q == chtt_pkg::CMD_ADD) begin
          if (any_free) begin
            res_status <= chtt_pkg::ST_OK;
            res_slot   <= free_x[5:0];
          end else begin
            res_status <= chtt_pkg::ST_FULL;
          end
        end else begin
          cur   <= head_of_bucket;
          prev  <= NIL;
          guard <= '0;
        end
      end
      chtt_pkg::S_CMP: begin
        if (hit) begin
          res_status <= chtt_pkg::ST_OK;
          res_slot   <= cur_x[5:0];
        end else begin
          prev     <= cur;
          prev_tag <= rd_tag;
          cur      <= rd_link;
          guard    <= guard + LW'(1);
        end
      end
      chtt_pkg::S_VISIT: begin
        res_status <= chtt_pkg::ST_OK;
        res_slot   <= wcur_x[5:0];
        res_tag    <= rd_tag;
      end
      chtt_pkg::S_DONE: begin
        if (rsp_free) begin
          rsp.status     <= res_status;
          rsp.slot_out   <= res_slot;
          rsp.tag_out    <= res_tag;
          rsp.item_count <= cnt_x[6:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
